FILE: rtl/core/atrm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the AT reply matcher.
// Depends on nothing; the matcher and its bench import it.
package atrm_pkg;

  // Default string capacities.
  localparam int unsigned PromptMaxDef = 8;
  localparam int unsigned TermMaxDef   = 16;

  // Response buffer capacity limit and the carriage return character.
  localparam logic [5:0] CapMax  = 6'd32;
  localparam logic [7:0] CharCr  = 8'h0D;

  // Configuration port geometry: 64-bit registers at byte address 8*i.
  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  // Register indexes, taken from paddr[5:3].
  localparam logic [2:0] RegPromptChars = 3'd0;
  localparam logic [2:0] RegPromptLen   = 3'd1;
  localparam logic [2:0] RegTermLow     = 3'd2;
  localparam logic [2:0] RegTermHigh    = 3'd3;
  localparam logic [2:0] RegTermLen     = 3'd4;
  localparam logic [2:0] RegRespCap     = 3'd5;

  // Register reset values; the default terminator is "OK\r\n".
  localparam logic [63:0] TermLowRst = 64'h0000_0000_0A0D_4B4F;
  localparam logic [4:0]  TermLenRst = 5'd4;

  // Matching phase of the current wait.
  typedef enum logic [1:0] {
    PH_PROMPT     = 2'd0,
    PH_GATHER     = 2'd1,
    PH_TERM_AFTER = 2'd2,
    PH_TERM_ONLY  = 2'd3
  } phase_e;

  // Request kinds.
  localparam logic ReqByte    = 1'b0;
  localparam logic ReqRestart = 1'b1;

endpackage

FILE: rtl/core/atrm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the AT reply matcher.
// Request channel carries one received byte or a restart; result channel one result item.
interface atrm_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface atrm_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] resp_char;
  logic       resp_char_valid;
  logic       prompt_complete;
  logic       done_res;

  modport source (output valid, output resp_char, output resp_char_valid,
                  output prompt_complete, output done_res, input ready);
  modport sink   (input valid, input resp_char, input resp_char_valid,
                  input prompt_complete, input done_res, output ready);
endinterface

FILE: rtl/core/at_response_matcher.sv
`timescale 1ns / 1ps
// Top level of the AT reply matcher: input register, matching logic, result register.
// Depends on atrm_pkg and the channel interfaces in atrm_if.sv.
//
// Usage: reply bytes from a modem arrive on req_i, one item per byte. A restart
// item (req_type 1) begins a new wait and clears all matching state. Every item
// gives exactly one result item on res_o: the response character gathered after
// the prompt (with resp_char_valid), the prompt_complete flag and done_res, which
// rises once the terminator has been seen. After done, bytes are ignored until a
// restart. Strings, lengths and the response capacity are set over the APB port;
// new lengths and capacity take effect for phase and space at the next restart.
//
// Timing: an item accepted into the input register is matched there by the
// combinational logic and its result is loaded into the result register, from which
// res_o offers it. One item is taken every cycle while res_o is not stalled;
// the rate is set by the single compare and position update per stage.
// When res_o is stalled the result register holds and the input register fills,
// after which req_i.ready drops. Reset empties both registers, sets the default
// terminator "OK\r\n", no prompt and zero capacity.
module at_response_matcher #(
  parameter int unsigned PROMPT_MAX = atrm_pkg::PromptMaxDef,
  parameter int unsigned TERM_MAX   = atrm_pkg::TermMaxDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  atrm_req_if.sink                    req_i,
  atrm_res_if.source                  res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [atrm_pkg::AddrW-1:0]  paddr,
  input  logic [atrm_pkg::DataW-1:0]  pwdata,
  output logic [atrm_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import atrm_pkg::*;

  // Position widths: positions run 0..MAX, indexes 0..MAX-1.
  localparam int unsigned PPosW = $clog2(PROMPT_MAX + 1);
  localparam int unsigned PIdxW = (PROMPT_MAX > 1) ? $clog2(PROMPT_MAX) : 1;
  localparam int unsigned TPosW = $clog2(TERM_MAX + 1);
  localparam int unsigned TIdxW = $clog2(TERM_MAX);

  // Configuration registers.
  logic [63:0] prompt_chars_q;
  logic [3:0]  prompt_length_q;
  logic [63:0] term_low_q;
  logic [63:0] term_high_q;
  logic [4:0]  term_length_q;
  logic [5:0]  resp_cap_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // Input register.
  logic        in_valid_q, in_valid_d;
  logic        in_req_type_q;
  logic [7:0]  in_rx_byte_q;

  // Matching state.
  logic [PPosW-1:0] prompt_pos_q, prompt_pos_d;
  logic [TPosW-1:0] term_pos_q, term_pos_d;
  phase_e           phase_q, phase_d;
  logic [5:0]       space_left_q, space_left_d;
  logic             finished_q, finished_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_char_q, out_char_d;
  logic        out_cvalid_q, out_cvalid_d;
  logic        out_pc_q, out_pc_d;
  logic        out_done_q, out_done_d;

  logic        req_fire;
  logic        s2_fire;

  // Effective lengths and character tables.
  logic [3:0]       plen_sat;
  logic [PPosW-1:0] plen;
  logic [4:0]       tlen_nz;
  logic [4:0]       tlen_sat;
  logic [TPosW-1:0] tlen;
  logic [5:0]       cap_sat;
  logic [PROMPT_MAX-1:0][7:0] prompt_bytes;
  logic [TERM_MAX-1:0][7:0]   term_bytes;
  logic [127:0]     term_all;
  logic [PPosW-1:0] pp;
  logic [TPosW-1:0] tp;
  logic [7:0]       c;

  // APB write decode; the port never waits.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prompt_chars_q  <= '0;
      prompt_length_q <= '0;
      term_low_q      <= TermLowRst;
      term_high_q     <= '0;
      term_length_q   <= TermLenRst;
      resp_cap_q      <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegPromptChars: prompt_chars_q  <= pwdata;
        RegPromptLen:   prompt_length_q <= pwdata[3:0];
        RegTermLow:     term_low_q      <= pwdata;
        RegTermHigh:    term_high_q     <= pwdata;
        RegTermLen:     term_length_q   <= pwdata[4:0];
        RegRespCap:     resp_cap_q      <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // APB read mux.
  always_comb begin
    case (cfg_idx)
      RegPromptChars: prdata = prompt_chars_q;
      RegPromptLen:   prdata = {60'd0, prompt_length_q};
      RegTermLow:     prdata = term_low_q;
      RegTermHigh:    prdata = term_high_q;
      RegTermLen:     prdata = {59'd0, term_length_q};
      RegRespCap:     prdata = {58'd0, resp_cap_q};
      default:        prdata = '0;
    endcase
  end

  // Handshakes: the input register advances whenever the result register frees.
  assign s2_fire     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || s2_fire;
  assign req_fire    = req_i.valid && req_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (req_fire) begin
      in_valid_d = 1'b1;
    end else if (s2_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      in_req_type_q <= req_i.req_type;
      in_rx_byte_q  <= req_i.rx_byte;
    end
  end

  // Saturated lengths and capacity.
  assign plen_sat = (prompt_length_q > 4'(PROMPT_MAX)) ? 4'(PROMPT_MAX) : prompt_length_q;
  assign plen     = PPosW'(plen_sat);
  assign tlen_nz  = (term_length_q == 5'd0) ? 5'd1 : term_length_q;
  assign tlen_sat = (tlen_nz > 5'(TERM_MAX)) ? 5'(TERM_MAX) : tlen_nz;
  assign tlen     = TPosW'(tlen_sat);
  assign cap_sat  = (resp_cap_q > CapMax) ? CapMax : resp_cap_q;

  assign prompt_bytes = prompt_chars_q[PROMPT_MAX*8-1:0];
  assign term_all     = {term_high_q, term_low_q};
  assign term_bytes   = term_all[TERM_MAX*8-1:0];
  assign c            = in_rx_byte_q;

  // A stored position at or beyond the current length counts as zero.
  assign pp = (prompt_pos_q >= plen) ? '0 : prompt_pos_q;
  assign tp = (term_pos_q >= tlen) ? '0 : term_pos_q;

  // Per-item matching step.
  always_comb begin
    prompt_pos_d = prompt_pos_q;
    term_pos_d   = term_pos_q;
    phase_d      = phase_q;
    space_left_d = space_left_q;
    finished_d   = finished_q;
    out_char_d   = 8'd0;
    out_cvalid_d = 1'b0;

    if (in_req_type_q == ReqRestart) begin
      prompt_pos_d = '0;
      term_pos_d   = '0;
      finished_d   = 1'b0;
      phase_d      = (plen != '0) ? PH_PROMPT : PH_TERM_ONLY;
      space_left_d = cap_sat;
    end else if (!finished_q) begin
      // Prompt search or response gathering.
      case (phase_q)
        PH_PROMPT: begin
          if (plen == '0) begin
            phase_d = PH_TERM_ONLY;
          end else if (c == prompt_bytes[PIdxW'(pp)]) begin
            prompt_pos_d = pp + PPosW'(1);
            if ((pp + PPosW'(1)) >= plen) begin
              phase_d = PH_GATHER;
            end
          end else begin
            prompt_pos_d = (c == prompt_bytes[0]) ? PPosW'(1) : '0;
          end
        end
        PH_GATHER: begin
          if (c == CharCr || space_left_q < 6'd2) begin
            phase_d = PH_TERM_AFTER;
          end else begin
            out_char_d   = c;
            out_cvalid_d = 1'b1;
            space_left_d = space_left_q - 6'd1;
          end
        end
        default: ;
      endcase

      // Terminator search runs on every byte.
      if (c == term_bytes[TIdxW'(tp)]) begin
        term_pos_d = tp + TPosW'(1);
        if ((tp + TPosW'(1)) >= tlen) begin
          finished_d = 1'b1;
        end
      end else begin
        term_pos_d = (c == term_bytes[0]) ? TPosW'(1) : '0;
      end
    end
  end

  // Result flags; a restart result is all zeros.
  always_comb begin
    if (in_req_type_q == ReqRestart) begin
      out_pc_d   = 1'b0;
      out_done_d = 1'b0;
    end else begin
      out_pc_d   = (phase_d == PH_GATHER) || (phase_d == PH_TERM_AFTER);
      out_done_d = finished_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prompt_pos_q <= '0;
      term_pos_q   <= '0;
      phase_q      <= PH_TERM_ONLY;
      space_left_q <= '0;
      finished_q   <= 1'b0;
    end else if (s2_fire) begin
      prompt_pos_q <= prompt_pos_d;
      term_pos_q   <= term_pos_d;
      phase_q      <= phase_d;
      space_left_q <= space_left_d;
      finished_q   <= finished_d;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s2_fire) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_char_q   <= out_char_d;
      out_cvalid_q <= out_cvalid_d;
      out_pc_q     <= out_pc_d;
      out_done_q   <= out_done_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.resp_char       = out_char_q;
  assign res_o.resp_char_valid = out_cvalid_q;
  assign res_o.prompt_complete = out_pc_q;
  assign res_o.done_res        = out_done_q;

`ifndef SYNTHESIS
  // A gathered character is only passed once the prompt has been seen.
  a_char_after_prompt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_cvalid_q) |-> out_pc_q)
    else $error("response character without a completed prompt");

  // Once done, a byte item reports done and passes no character.
  a_ignore_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && finished_q && (in_req_type_q == ReqByte))
      |=> (out_valid_q && out_done_q && !out_cvalid_q))
    else $error("byte after done was not ignored");

  // The remaining space never exceeds the capacity limit.
  a_space_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |=> (space_left_q <= CapMax))
    else $error("space left above capacity limit");
`endif

endmodule

FILE: verif/tb_at_response_matcher.sv
`timescale 1ns / 1ps
// Self-checking bench for at_response_matcher: directed reply scenarios, then random modem traffic.
// Uses atrm_pkg, the channel interfaces in atrm_if.sv and the matcher RTL; needs nothing else.
module tb_at_response_matcher;
  import atrm_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [7:0]  CharLf        = 8'h0A;

  // One result item as the matcher reports it.
  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       prompt_seen;
    logic       done;
  } reply_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  atrm_req_if req_if ();
  atrm_res_if res_if ();

  at_response_matcher u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the registers, starting at their reset values.
  logic [63:0] cfg_prompt_chars = '0;
  logic [3:0]  cfg_prompt_len   = '0;
  logic [63:0] cfg_term_low     = TermLowRst;
  logic [63:0] cfg_term_high    = '0;
  logic [4:0]  cfg_term_len     = TermLenRst;
  logic [5:0]  cfg_resp_cap     = '0;

  // Matching state of the current wait; reset leaves no prompt and zero capacity.
  logic [3:0] m_prompt_pos = '0;
  logic [4:0] m_term_pos   = '0;
  phase_e     m_phase      = PH_TERM_ONLY;
  logic [5:0] m_space      = '0;
  logic       m_done       = 1'b0;

  reply_t pending_replies[$];
  int     mismatches      = 0;
  int     reply_items     = 0;
  int     sender_idle_pct = 0;
  int     recv_stall_pct  = 0;
  int     idle_cycles     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] eff_prompt_len();
    return (cfg_prompt_len > 4'd8) ? 4'd8 : cfg_prompt_len;
  endfunction

  function automatic logic [4:0] eff_term_len();
    if (cfg_term_len == 5'd0) begin
      return 5'd1;
    end
    return (cfg_term_len > 5'd16) ? 5'd16 : cfg_term_len;
  endfunction

  // Advances the shadow state by one item and returns the result it should produce.
  function automatic reply_t match_reply_byte(logic kind, logic [7:0] c);
    reply_t       r;
    logic [3:0]   plen;
    logic [4:0]   tlen;
    logic [127:0] term_str;
    r        = '0;
    plen     = eff_prompt_len();
    tlen     = eff_term_len();
    term_str = {cfg_term_high, cfg_term_low};

    // A restart clears the wait and takes lengths and capacity from the live registers.
    if (kind == ReqRestart) begin
      m_prompt_pos = '0;
      m_term_pos   = '0;
      m_done       = 1'b0;
      if (plen != 4'd0) begin
        m_phase = PH_PROMPT;
      end else begin
        m_phase = PH_TERM_ONLY;
      end
      m_space = (cfg_resp_cap > CapMax) ? CapMax : cfg_resp_cap;
      return r;
    end

    if (!m_done) begin
      case (m_phase)
        PH_PROMPT: begin
          if (plen == 4'd0) begin
            m_phase = PH_TERM_ONLY;
          end else begin
            if (m_prompt_pos >= plen) begin
              m_prompt_pos = '0;
            end
            if (c == cfg_prompt_chars[8*m_prompt_pos[2:0] +: 8]) begin
              m_prompt_pos++;
              if (m_prompt_pos >= plen) begin
                m_phase = PH_GATHER;
              end
            end else begin
              m_prompt_pos = (c == cfg_prompt_chars[7:0]) ? 4'd1 : 4'd0;
            end
          end
        end
        PH_GATHER: begin
          if (c == CharCr || m_space < 6'd2) begin
            m_phase = PH_TERM_AFTER;
          end else begin
            r.ch       = c;
            r.ch_valid = 1'b1;
            m_space--;
          end
        end
        default: ;
      endcase

      // The terminator is watched on every byte, whatever the phase.
      if (m_term_pos >= tlen) begin
        m_term_pos = '0;
      end
      if (c == term_str[8*m_term_pos[3:0] +: 8]) begin
        m_term_pos++;
        if (m_term_pos >= tlen) begin
          m_done = 1'b1;
        end
      end else begin
        m_term_pos = (c == term_str[7:0]) ? 5'd1 : 5'd0;
      end
    end

    r.prompt_seen = (m_phase == PH_GATHER || m_phase == PH_TERM_AFTER);
    r.done        = m_done;
    return r;
  endfunction

  // Offers one item, waits for it to be taken and records the result it must give.
  task automatic send_item(input logic kind, input logic [7:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.rx_byte  <= c;
    @(posedge clk_i);
    while (!req_if.ready) begin
      @(posedge clk_i);
    end
    reply_items++;
    pending_replies.push_back(match_reply_byte(kind, c));
  endtask

  // Stops sending and lets every outstanding result come back, plus the pipeline depth.
  task automatic wait_replies_drained();
    req_if.valid <= 1'b0;
    while (pending_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Register write over APB: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegPromptChars: cfg_prompt_chars = val;
      RegPromptLen:   cfg_prompt_len   = val[3:0];
      RegTermLow:     cfg_term_low     = val;
      RegTermHigh:    cfg_term_high    = val;
      RegTermLen:     cfg_term_len     = val[4:0];
      RegRespCap:     cfg_resp_cap     = val[5:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Either a fully random string or one drawn from two letters, so that
  // partial matches and the restart rule come up often.
  function automatic logic [63:0] random_string(input logic [7:0] a, input logic [7:0] b);
    logic [63:0] s;
    if ($urandom_range(1) == 0) begin
      s = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < 8; i++) begin
        s[8*i +: 8] = ($urandom_range(1) == 0) ? a : b;
      end
    end
    return s;
  endfunction

  // Loads a full register set; the first kinds pin the lengths to their extremes.
  task automatic configure_matcher(input int kind);
    logic [3:0] plen;
    logic [4:0] tlen;
    logic [5:0] cap;
    case (kind)
      0: begin plen = 4'hF; tlen = 5'h1F; cap = 6'h3F; end
      1: begin plen = 4'd0; tlen = 5'd0;  cap = 6'd0;  end
      2: begin plen = 4'd8; tlen = 5'd16; cap = 6'd32; end
      default: begin
        plen = 4'($urandom_range(0, 15));
        tlen = 5'($urandom_range(0, 31));
        cap  = 6'($urandom_range(0, 63));
      end
    endcase
    write_reg(RegPromptChars, random_string("A", "B"));
    write_reg(RegPromptLen, {60'd0, plen});
    write_reg(RegTermLow, random_string("O", "K"));
    write_reg(RegTermHigh, random_string("O", CharCr));
    write_reg(RegTermLen, {59'd0, tlen});
    write_reg(RegRespCap, {58'd0, cap});
  endtask

  // One modem reply: restart, line noise, prompt, response body, carriage return,
  // terminator and trailing bytes. Each part is sometimes broken or left out.
  task automatic send_reply_sequence();
    logic [3:0]   plen;
    logic [4:0]   tlen;
    logic [127:0] term_str;
    logic [7:0]   c;
    int           body_len;
    plen     = eff_prompt_len();
    tlen     = eff_term_len();
    term_str = {cfg_term_high, cfg_term_low};
    if ($urandom_range(9) != 0) begin
      send_item(ReqRestart, 8'($urandom));
    end
    repeat ($urandom_range(0, 3)) send_item(ReqByte, 8'($urandom));
    for (int i = 0; i < plen; i++) begin
      c = cfg_prompt_chars[8*i +: 8];
      if ($urandom_range(19) == 0) begin
        c = 8'($urandom);
      end
      send_item(ReqByte, c);
    end
    // Mostly short bodies; now and then one long enough to exhaust the capacity.
    body_len = ($urandom_range(9) == 0) ? $urandom_range(0, 36) : $urandom_range(0, 6);
    for (int i = 0; i < body_len; i++) begin
      c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
      send_item(ReqByte, c);
    end
    if ($urandom_range(9) < 7) begin
      send_item(ReqByte, CharCr);
    end
    for (int i = 0; i < tlen; i++) begin
      c = term_str[8*i +: 8];
      if ($urandom_range(19) == 0) begin
        c = 8'($urandom);
      end
      send_item(ReqByte, c);
    end
    repeat ($urandom_range(0, 2)) send_item(ReqByte, 8'($urandom));
  endtask

  // Reset configuration: no prompt, terminator "OK\r\n", then a byte after done.
  task automatic test_default_terminator();
    send_item(ReqByte, 8'h00);
    send_item(ReqByte, "O");
    send_item(ReqByte, "O");
    send_item(ReqByte, "K");
    send_item(ReqByte, CharCr);
    send_item(ReqByte, CharLf);
    send_item(ReqByte, 8'hFF);
    wait_replies_drained();
  endtask

  // Two-character prompt with a repeated first character, then gathering
  // until the capacity runs out.
  task automatic test_prompt_gather();
    write_reg(RegPromptChars, 64'h3EFF);
    write_reg(RegPromptLen, 64'd2);
    write_reg(RegRespCap, 64'd3);
    send_item(ReqRestart, 8'hA5);
    send_item(ReqByte, 8'hFF);
    send_item(ReqByte, 8'hFF);
    send_item(ReqByte, ">");
    send_item(ReqByte, "a");
    send_item(ReqByte, "b");
    send_item(ReqByte, "c");
    wait_replies_drained();
  endtask

  // Oversized prompt length, zero terminator length, capacity below two, and
  // lengths changed in the middle of a wait.
  task automatic test_special_lengths();
    write_reg(RegPromptLen, 64'd15);
    write_reg(RegTermLen, 64'd0);
    write_reg(RegTermLow, 64'h7E);
    write_reg(RegTermHigh, '1);
    write_reg(RegRespCap, 64'd1);
    send_item(ReqRestart, 8'h00);
    send_item(ReqByte, 8'hFF);
    send_item(ReqByte, ">");
    wait_replies_drained();

    // The stored prompt position now lies past the shorter prompt.
    write_reg(RegPromptLen, 64'd1);
    send_item(ReqByte, 8'hFF);
    send_item(ReqByte, "z");
    send_item(ReqByte, "~");
    send_item(ReqRestart, 8'hFF);
    wait_replies_drained();

    // The prompt disappears while the matcher is still searching for it.
    write_reg(RegPromptLen, 64'd0);
    send_item(ReqByte, "q");
    wait_replies_drained();
  endtask

  // Random replies under one idling pattern, with the registers reloaded now and then.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
    int start_count;
    int seq_no;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    start_count     = reply_items;
    seq_no          = 0;
    while (reply_items - start_count < n_items) begin
      if (seq_no % 10 == 0) begin
        wait_replies_drained();
        configure_matcher((seq_no / 10) % 5);
      end
      send_reply_sequence();
      seq_no++;
    end
    wait_replies_drained();
  endtask

  // Receiver side: ready follows the current stall rate.
  initial begin
    res_if.ready <= 1'b0;
    forever @(posedge clk_i) res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: result with no item pending, actual char %0h valid %0b prompt %0b done %0b",
                 $time, res_if.resp_char, res_if.resp_char_valid, res_if.prompt_complete,
                 res_if.done_res);
      end else begin
        want = pending_replies.pop_front();
        check_field("resp_char", want.ch, res_if.resp_char);
        check_field("resp_char_valid", {7'd0, want.ch_valid}, {7'd0, res_if.resp_char_valid});
        check_field("prompt_complete", {7'd0, want.prompt_seen}, {7'd0, res_if.prompt_complete});
        check_field("done_res", {7'd0, want.done}, {7'd0, res_if.done_res});
      end
    end
  end

  // Watchdog: too long without any handshake or register access means a hang.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= ReqByte;
    req_if.rx_byte  <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_terminator();
    test_prompt_gather();
    test_special_lengths();
    test_random_traffic(0, 0, 375);
    test_random_traffic(61, 0, 375);
    test_random_traffic(0, 61, 375);
    test_random_traffic(15, 15, 375);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
